FILE: rtl/rbffd_pkg.sv
// Shared types, constants and saturation helper for the shallow water tendency block.
`timescale 1ns / 1ps

package rbffd_pkg;

    localparam int ACC_BITS       = 48;
    localparam int IN_BITS        = 32;
    localparam int OUT_BITS       = 32;
    localparam int WIDE_BITS      = 64;
    localparam int NUM_LANES      = 16;
    localparam int NUM_VALUES     = 8;
    localparam int DEF_FRAC_BITS  = 16;
    localparam int DEF_VALUE_BITS = 32;

    typedef enum logic [1:0] {
        ACT_NEIGHBOR = 2'd0,
        ACT_NODE     = 2'd1,
        ACT_PROJ_A   = 2'd2,
        ACT_PROJ_B   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NB_GO,
        ST_NB_WAIT,
        ST_MOM_GO,
        ST_MOM_WAIT,
        ST_COR_GO,
        ST_COR_WAIT,
        ST_PREP,
        ST_EMIT_GO,
        ST_EMIT_WAIT
    } seq_state_t;

    // Request from the sequencer to one multiplier lane.
    typedef struct packed {
        logic                       start;
        logic                       to_acc;
        logic signed [ACC_BITS-1:0] op_a;
        logic signed [ACC_BITS-1:0] op_b;
    } lane_req_t;

    // Result of one multiplier lane; product and clip flag are held until the next pass finishes.
    typedef struct packed {
        logic                       done;
        logic                       clip;
        logic signed [ACC_BITS-1:0] prod;
    } lane_rsp_t;

    typedef struct packed {
        logic                        clip;
        logic signed [WIDE_BITS-1:0] val;
    } sat_res_t;

    // Clamp a wide signed value to a signed range of the given width.
    function automatic sat_res_t sat_to(input logic signed [WIDE_BITS-1:0] v,
                                        input int bits);
        sat_res_t                    r;
        logic signed [WIDE_BITS-1:0] lim;
        lim    = $signed(WIDE_BITS'(1)) <<< (bits - 1);
        r.clip = 1'b0;
        r.val  = v;
        if (v > lim - 1) begin
            r.clip = 1'b1;
            r.val  = lim - 1;
        end else if (v < -lim) begin
            r.clip = 1'b1;
            r.val  = -lim;
        end
        return r;
    endfunction

endpackage

FILE: rtl/rbffd_shallow_water_rhs_top.sv
// Top level: stream ports, sequencer, sixteen multiplier lanes and the merging stage.
// Neighbour transaction: accepted when idle, one lane pass; no new input until it is done.
// Node transaction: two lane passes; projection part one is stored without leaving idle.
// Projection part two: a prep step, then one lane pass; the next input is taken only once
// the result has been written to the output register, which waits for it to be free.
// Synchronous active-low reset clears control, model and gh0 state (not payload) at once.
`timescale 1ns / 1ps

module rbffd_shallow_water_rhs_top #(
    parameter int FRAC_BITS  = rbffd_pkg::DEF_FRAC_BITS,
    parameter int VALUE_BITS = rbffd_pkg::DEF_VALUE_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,   // gh0_offset
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,       // value_0 .. value_7, 32 bits each
    input  logic [1:0]   s_tuser,       // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,       // tend_u, tend_v, tend_w, tend_h
    output logic [0:0]   m_tuser        // saturated
);

    localparam int ACC  = rbffd_pkg::ACC_BITS;
    localparam int INB  = rbffd_pkg::IN_BITS;
    localparam int OUTB = rbffd_pkg::OUT_BITS;
    localparam int WB   = rbffd_pkg::WIDE_BITS;
    localparam int NL   = rbffd_pkg::NUM_LANES;
    localparam int NV   = rbffd_pkg::NUM_VALUES;
    localparam int PSUM_BITS = VALUE_BITS + 3;

    rbffd_pkg::seq_state_t state_reg, state_next;

    logic signed [INB-1:0]        v_reg     [NV];
    logic signed [INB-1:0]        v_next    [NV];
    logic signed [INB-1:0]        gh0_reg;
    logic signed [ACC-1:0]        sums_reg  [16];
    logic signed [ACC-1:0]        sums_next [16];
    logic signed [INB-1:0]        node_reg  [4];
    logic signed [INB-1:0]        node_next [4];
    logic signed [INB-1:0]        rows_reg  [6];
    logic signed [INB-1:0]        rows_next [6];
    logic signed [INB-1:0]        mg_reg, mg_next;
    logic signed [VALUE_BITS-1:0] cor_reg   [3];
    logic signed [VALUE_BITS-1:0] cor_next  [3];
    logic signed [PSUM_BITS-1:0]  psum_reg  [3];
    logic signed [PSUM_BITS-1:0]  psum_next [3];
    logic signed [VALUE_BITS-1:0] mom_reg   [3];
    logic signed [VALUE_BITS-1:0] mom_next  [3];
    logic signed [VALUE_BITS-1:0] g_reg     [3];
    logic signed [VALUE_BITS-1:0] g_next    [3];
    logic signed [VALUE_BITS-1:0] depth_reg, depth_next;
    logic signed [VALUE_BITS-1:0] div_reg, div_next;
    logic                         clip_reg, clip_next;
    logic [OUTB-1:0]              tend_reg  [4];
    logic [OUTB-1:0]              tend_next [4];
    logic                         osat_reg, osat_next;
    logic                         mvalid_reg, mvalid_next;

    rbffd_pkg::lane_req_t lane_req [NL];
    rbffd_pkg::lane_rsp_t lane_rsp [NL];
    logic                 lane_clip_any;
    logic                 s_fire;

    // Multiplier lanes.
    for (genvar l = 0; l < NL; l++) begin : g_lane
        rbffd_mul_lane #(
            .FRAC_BITS (FRAC_BITS),
            .VALUE_BITS(VALUE_BITS)
        ) u_lane (
            .aclk   (aclk),
            .aresetn(aresetn),
            .req    (lane_req[l]),
            .rsp    (lane_rsp[l])
        );
    end

    always_comb begin
        lane_clip_any = 1'b0;
        for (int l = 0; l < NL; l++) begin
            lane_clip_any = lane_clip_any | lane_rsp[l].clip;
        end
    end

    // Lane operand selection for each pass.
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            lane_req[l] = '0;
        end
        case (state_reg)
            rbffd_pkg::ST_NB_GO: begin
                for (int d = 0; d < 4; d++) begin
                    for (int k = 0; k < 4; k++) begin
                        lane_req[d*4+k].op_a   = ACC'(v_reg[d]);
                        lane_req[d*4+k].op_b   = ACC'(v_reg[4+k]);
                        lane_req[d*4+k].to_acc = 1'b1;
                    end
                end
                for (int l = 0; l < NL; l++) begin
                    lane_req[l].start = 1'b1;
                end
            end
            rbffd_pkg::ST_MOM_GO: begin
                // Cross product terms: y*w, z*v, z*u, x*w, x*v, y*u.
                lane_req[0].op_a = ACC'(v_reg[6]);
                lane_req[0].op_b = ACC'(v_reg[2]);
                lane_req[1].op_a = ACC'(v_reg[7]);
                lane_req[1].op_b = ACC'(v_reg[1]);
                lane_req[2].op_a = ACC'(v_reg[7]);
                lane_req[2].op_b = ACC'(v_reg[0]);
                lane_req[3].op_a = ACC'(v_reg[5]);
                lane_req[3].op_b = ACC'(v_reg[2]);
                lane_req[4].op_a = ACC'(v_reg[5]);
                lane_req[4].op_b = ACC'(v_reg[1]);
                lane_req[5].op_a = ACC'(v_reg[6]);
                lane_req[5].op_b = ACC'(v_reg[0]);
                // Advection terms: velocity component times first derivatives.
                for (int k = 0; k < 3; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        lane_req[6+k*3+j].op_a = ACC'(v_reg[j]);
                        lane_req[6+k*3+j].op_b = sums_reg[j*4+k];
                    end
                end
                for (int l = 0; l < NL; l++) begin
                    lane_req[l].start = 1'b1;
                end
            end
            rbffd_pkg::ST_COR_GO: begin
                for (int k = 0; k < 3; k++) begin
                    lane_req[k].op_a = ACC'(v_reg[4]);
                    lane_req[k].op_b = ACC'(cor_reg[k]);
                end
                for (int l = 0; l < NL; l++) begin
                    lane_req[l].start = 1'b1;
                end
            end
            rbffd_pkg::ST_EMIT_GO: begin
                // Rows p_u and p_v come from the stored rows, p_w from the payload.
                for (int k = 0; k < 2; k++) begin
                    for (int j = 0; j < 3; j++) begin
                        lane_req[k*3+j].op_a = ACC'(rows_reg[k*3+j]);
                        lane_req[k*3+j].op_b = ACC'(mom_reg[j]);
                    end
                end
                for (int j = 0; j < 3; j++) begin
                    lane_req[6+j].op_a = ACC'(v_reg[j]);
                    lane_req[6+j].op_b = ACC'(mom_reg[j]);
                end
                for (int d = 0; d < 3; d++) begin
                    lane_req[9+d].op_a = ACC'(node_reg[d]);
                    lane_req[9+d].op_b = ACC'(g_reg[d]);
                end
                lane_req[12].op_a = ACC'(depth_reg);
                lane_req[12].op_b = ACC'(div_reg);
                for (int l = 0; l < NL; l++) begin
                    lane_req[l].start = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_tready = (state_reg == rbffd_pkg::ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // Sequencer and merging stage.
    always_comb begin
        rbffd_pkg::sat_res_t   r1, r2, r3;
        logic signed [WB-1:0]  s;
        logic                  c;
        state_next  = state_reg;
        mg_next     = mg_reg;
        depth_next  = depth_reg;
        div_next    = div_reg;
        clip_next   = clip_reg;
        osat_next   = osat_reg;
        mvalid_next = mvalid_reg && !m_tready;
        for (int i = 0; i < NV; i++) v_next[i] = v_reg[i];
        for (int i = 0; i < 16; i++) sums_next[i] = sums_reg[i];
        for (int i = 0; i < 4; i++) node_next[i] = node_reg[i];
        for (int i = 0; i < 6; i++) rows_next[i] = rows_reg[i];
        for (int i = 0; i < 3; i++) begin
            cor_next[i]  = cor_reg[i];
            psum_next[i] = psum_reg[i];
            mom_next[i]  = mom_reg[i];
            g_next[i]    = g_reg[i];
        end
        for (int i = 0; i < 4; i++) tend_next[i] = tend_reg[i];
        r1 = '0;
        r2 = '0;
        r3 = '0;
        s  = '0;
        c  = 1'b0;

        case (state_reg)
            rbffd_pkg::ST_IDLE: begin
                if (s_fire) begin
                    for (int i = 0; i < NV; i++) v_next[i] = s_tdata[i*INB +: INB];
                    case (rbffd_pkg::action_t'(s_tuser))
                        rbffd_pkg::ACT_NEIGHBOR: state_next = rbffd_pkg::ST_NB_GO;
                        rbffd_pkg::ACT_NODE: begin
                            for (int i = 0; i < 4; i++) node_next[i] = s_tdata[i*INB +: INB];
                            state_next = rbffd_pkg::ST_MOM_GO;
                        end
                        rbffd_pkg::ACT_PROJ_A: begin
                            for (int i = 0; i < 6; i++) rows_next[i] = s_tdata[i*INB +: INB];
                            mg_next = s_tdata[6*INB +: INB];
                        end
                        rbffd_pkg::ACT_PROJ_B: state_next = rbffd_pkg::ST_PREP;
                        default: state_next = rbffd_pkg::ST_IDLE;
                    endcase
                end
            end
            rbffd_pkg::ST_NB_GO: state_next = rbffd_pkg::ST_NB_WAIT;
            rbffd_pkg::ST_NB_WAIT: begin
                if (lane_rsp[0].done) begin
                    c = lane_clip_any;
                    for (int i = 0; i < 16; i++) begin
                        r1 = rbffd_pkg::sat_to(WB'(sums_reg[i]) + WB'($signed(lane_rsp[i].prod)),
                                               ACC);
                        sums_next[i] = r1.val[ACC-1:0];
                        c = c | r1.clip;
                    end
                    clip_next  = clip_reg | c;
                    state_next = rbffd_pkg::ST_IDLE;
                end
            end
            rbffd_pkg::ST_MOM_GO: state_next = rbffd_pkg::ST_MOM_WAIT;
            rbffd_pkg::ST_MOM_WAIT: begin
                if (lane_rsp[0].done) begin
                    c = lane_clip_any;
                    for (int k = 0; k < 3; k++) begin
                        r1 = rbffd_pkg::sat_to(WB'($signed(lane_rsp[2*k].prod))
                                               - WB'($signed(lane_rsp[2*k+1].prod)), VALUE_BITS);
                        cor_next[k] = r1.val[VALUE_BITS-1:0];
                        r2 = rbffd_pkg::sat_to(WB'(sums_reg[k*4+3]), VALUE_BITS);
                        s  = WB'($signed(lane_rsp[6+k*3].prod))
                           + WB'($signed(lane_rsp[7+k*3].prod))
                           + WB'($signed(lane_rsp[8+k*3].prod)) + r2.val;
                        psum_next[k] = s[PSUM_BITS-1:0];
                        c = c | r1.clip | r2.clip;
                    end
                    clip_next  = clip_reg | c;
                    state_next = rbffd_pkg::ST_COR_GO;
                end
            end
            rbffd_pkg::ST_COR_GO: state_next = rbffd_pkg::ST_COR_WAIT;
            rbffd_pkg::ST_COR_WAIT: begin
                if (lane_rsp[0].done) begin
                    c = lane_clip_any;
                    for (int k = 0; k < 3; k++) begin
                        s  = WB'(psum_reg[k]) + WB'($signed(lane_rsp[k].prod));
                        r1 = rbffd_pkg::sat_to(s, VALUE_BITS);
                        r2 = rbffd_pkg::sat_to(-r1.val, VALUE_BITS);
                        mom_next[k] = r2.val[VALUE_BITS-1:0];
                        c = c | r1.clip | r2.clip;
                    end
                    clip_next  = clip_reg | c;
                    state_next = rbffd_pkg::ST_IDLE;
                end
            end
            rbffd_pkg::ST_PREP: begin
                // Gradient corrections, fluid depth and velocity divergence.
                for (int d = 0; d < 3; d++) begin
                    r1 = rbffd_pkg::sat_to(WB'(sums_reg[d*4+3]) - WB'(v_reg[3+d]), VALUE_BITS);
                    g_next[d] = r1.val[VALUE_BITS-1:0];
                    c = c | r1.clip;
                end
                r2 = rbffd_pkg::sat_to(WB'(node_reg[3]) + WB'(gh0_reg) - WB'(mg_reg), VALUE_BITS);
                depth_next = r2.val[VALUE_BITS-1:0];
                r3 = rbffd_pkg::sat_to(WB'(sums_reg[0]) + WB'(sums_reg[5]) + WB'(sums_reg[10]),
                                       VALUE_BITS);
                div_next   = r3.val[VALUE_BITS-1:0];
                clip_next  = clip_reg | c | r2.clip | r3.clip;
                state_next = rbffd_pkg::ST_EMIT_GO;
            end
            rbffd_pkg::ST_EMIT_GO: state_next = rbffd_pkg::ST_EMIT_WAIT;
            rbffd_pkg::ST_EMIT_WAIT: begin
                // Emit once the lanes are done and the output register is free.
                if (lane_rsp[0].done && (!mvalid_reg || m_tready)) begin
                    c = lane_clip_any;
                    for (int k = 0; k < 3; k++) begin
                        s  = WB'($signed(lane_rsp[k*3].prod))
                           + WB'($signed(lane_rsp[k*3+1].prod))
                           + WB'($signed(lane_rsp[k*3+2].prod));
                        r1 = rbffd_pkg::sat_to(s, VALUE_BITS);
                        r2 = rbffd_pkg::sat_to(r1.val + WB'(sums_reg[12+k]), OUTB);
                        tend_next[k] = r2.val[OUTB-1:0];
                        c = c | r1.clip | r2.clip;
                    end
                    s  = WB'($signed(lane_rsp[9].prod)) + WB'($signed(lane_rsp[10].prod))
                       + WB'($signed(lane_rsp[11].prod)) + WB'($signed(lane_rsp[12].prod));
                    r1 = rbffd_pkg::sat_to(s, VALUE_BITS);
                    r2 = rbffd_pkg::sat_to(-r1.val, VALUE_BITS);
                    r3 = rbffd_pkg::sat_to(r2.val + WB'(sums_reg[15]), OUTB);
                    tend_next[3] = r3.val[OUTB-1:0];
                    osat_next    = clip_reg | c | r1.clip | r2.clip | r3.clip;
                    mvalid_next  = 1'b1;
                    clip_next    = 1'b0;
                    for (int i = 0; i < 16; i++) sums_next[i] = '0;
                    state_next = rbffd_pkg::ST_IDLE;
                end
            end
            default: state_next = rbffd_pkg::ST_IDLE;
        endcase
    end

    // State and stored model variables.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rbffd_pkg::ST_IDLE;
            clip_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            mg_reg     <= '0;
            for (int i = 0; i < 16; i++) sums_reg[i] <= '0;
            for (int i = 0; i < 4; i++) node_reg[i] <= '0;
            for (int i = 0; i < 6; i++) rows_reg[i] <= '0;
            for (int i = 0; i < 3; i++) mom_reg[i] <= '0;
        end else begin
            state_reg  <= state_next;
            clip_reg   <= clip_next;
            mvalid_reg <= mvalid_next;
            mg_reg     <= mg_next;
            for (int i = 0; i < 16; i++) sums_reg[i] <= sums_next[i];
            for (int i = 0; i < 4; i++) node_reg[i] <= node_next[i];
            for (int i = 0; i < 6; i++) rows_reg[i] <= rows_next[i];
            for (int i = 0; i < 3; i++) mom_reg[i] <= mom_next[i];
        end
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gh0_reg <= '0;
        end else if (cfg_wr_en) begin
            gh0_reg <= cfg_wr_data;
        end
    end

    // Working payload registers.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NV; i++) v_reg[i] <= v_next[i];
        for (int i = 0; i < 3; i++) begin
            cor_reg[i]  <= cor_next[i];
            psum_reg[i] <= psum_next[i];
            g_reg[i]    <= g_next[i];
        end
        depth_reg <= depth_next;
        div_reg   <= div_next;
        for (int i = 0; i < 4; i++) tend_reg[i] <= tend_next[i];
        osat_reg  <= osat_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {tend_reg[3], tend_reg[2], tend_reg[1], tend_reg[0]};
    assign m_tuser  = osat_reg;

endmodule

FILE: rtl/rbffd_mul_lane.sv
// One multiplier lane: rounded, saturated fixed point product over four partial products.
`timescale 1ns / 1ps

module rbffd_mul_lane #(
    parameter int FRAC_BITS  = rbffd_pkg::DEF_FRAC_BITS,
    parameter int VALUE_BITS = rbffd_pkg::DEF_VALUE_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rbffd_pkg::lane_req_t req,
    output rbffd_pkg::lane_rsp_t rsp
);

    localparam int OPW       = rbffd_pkg::ACC_BITS;
    localparam int HALF      = OPW / 2;
    localparam int PROD_BITS = 2 * OPW;
    localparam logic [2:0] STEP_IDLE     = 3'd0;
    localparam logic [2:0] STEP_FIRST    = 3'd1;
    localparam logic [2:0] STEP_LAST_MUL = 3'd4;
    localparam logic [2:0] STEP_LAST_ADD = 3'd5;
    localparam logic [2:0] STEP_FINISH   = 3'd6;
    localparam logic [2:0] STEP_DONE     = 3'd7;

    logic [OPW-1:0]       mag_a_reg, mag_b_reg;
    logic                 neg_reg, to_acc_reg;
    logic [2:0]           step_reg;
    logic [PROD_BITS-1:0] pp_reg, acc_reg;
    logic signed [OPW-1:0] prod_reg;
    logic                 clip_reg;

    logic [OPW-1:0]       mag_a, mag_b;
    logic [1:0]           part_idx;
    logic [HALF-1:0]      part_a, part_b;
    logic [2*HALF-1:0]    part_mul;
    logic [PROD_BITS-1:0] pp_next;
    logic [PROD_BITS-1:0] rnd, mag, lim, cap, mag_clamped;
    logic                 over;
    logic signed [OPW-1:0] res;

    // Operand magnitudes at start.
    assign mag_a = req.op_a[OPW-1] ? OPW'(-req.op_a) : OPW'(req.op_a);
    assign mag_b = req.op_b[OPW-1] ? OPW'(-req.op_b) : OPW'(req.op_b);

    // Partial product of the current step, placed at its weight.
    assign part_idx = 2'(step_reg - STEP_FIRST);
    assign part_a   = part_idx[1] ? mag_a_reg[OPW-1:HALF] : mag_a_reg[HALF-1:0];
    assign part_b   = part_idx[0] ? mag_b_reg[OPW-1:HALF] : mag_b_reg[HALF-1:0];
    assign part_mul = part_a * part_b;

    always_comb begin
        case (part_idx)
            2'd0:    pp_next = PROD_BITS'(part_mul);
            2'd3:    pp_next = PROD_BITS'(part_mul) << (2 * HALF);
            default: pp_next = PROD_BITS'(part_mul) << HALF;
        endcase
    end

    // Round half away from zero, shift down and clamp the magnitude.
    always_comb begin
        rnd  = acc_reg + (PROD_BITS'(1) << (FRAC_BITS - 1));
        mag  = rnd >> FRAC_BITS;
        lim  = to_acc_reg ? (PROD_BITS'(1) << (OPW - 1)) : (PROD_BITS'(1) << (VALUE_BITS - 1));
        cap  = neg_reg ? lim : lim - PROD_BITS'(1);
        over = mag > cap;
        mag_clamped = over ? cap : mag;
        res  = neg_reg ? -$signed(mag_clamped[OPW-1:0]) : $signed(mag_clamped[OPW-1:0]);
    end

    // Step sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_IDLE;
        end else if (req.start) begin
            step_reg <= STEP_FIRST;
        end else if (step_reg != STEP_IDLE && step_reg != STEP_DONE) begin
            step_reg <= step_reg + 3'd1;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (req.start) begin
            mag_a_reg  <= mag_a;
            mag_b_reg  <= mag_b;
            neg_reg    <= req.op_a[OPW-1] ^ req.op_b[OPW-1];
            to_acc_reg <= req.to_acc;
            acc_reg    <= '0;
            pp_reg     <= '0;
        end else if (step_reg >= STEP_FIRST && step_reg <= STEP_LAST_ADD) begin
            acc_reg <= acc_reg + pp_reg;
            pp_reg  <= (step_reg <= STEP_LAST_MUL) ? pp_next : '0;
        end else if (step_reg == STEP_FINISH) begin
            prod_reg <= res;
            clip_reg <= over;
        end
    end

    assign rsp.done = (step_reg == STEP_DONE);
    assign rsp.clip = clip_reg;
    assign rsp.prod = prod_reg;

endmodule

FILE: tb/tb_rbffd_shallow_water_rhs_top.sv
// Self-checking testbench for the shallow water tendency block, with its own fixed-point predictor.
`timescale 1ns / 1ps

module tb_rbffd_shallow_water_rhs_top;
    import rbffd_pkg::*;

    localparam int FRAC       = 16;
    localparam int VBITS      = 32;
    localparam int RAND_ITEMS = 1700;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] w;
        logic [31:0] h;
        logic        sat;
    } tendency_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [31:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;

    // Predictor state, mirroring the block's registers.
    longint gh0;
    longint sums [16];
    longint node_state [4];
    longint momentum [3];
    longint rows_uv [6];
    longint mean_gp;
    bit     clipped;

    tendency_t tend_queue [$];
    int        mismatches;
    int        tend_seen;
    int        items_by_action [4];
    int        hold_cycles;
    bit        quiet;
    int        idle_count;

    rbffd_shallow_water_rhs_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Clamp to a signed width, noting any clip.
    function automatic longint clamp(longint v, int bits);
        longint lim;
        lim = longint'(1) <<< (bits - 1);
        if (v > lim - 1) begin
            clipped = 1'b1;
            return lim - 1;
        end
        if (v < -lim) begin
            clipped = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    // Fixed-point product, rounded half away from zero, then clamped.
    function automatic longint qmul(longint a, longint b, int bits);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [127:0] lim;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        p   = {64'd0, ua} * {64'd0, ub};
        p   = (p + (128'd1 << (FRAC - 1))) >> FRAC;
        lim = 128'd1 << (bits - 1);
        if (p > (neg ? lim : lim - 1)) begin
            clipped = 1'b1;
            p = neg ? lim : lim - 1;
        end
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint vmul(longint a, longint b);
        return qmul(a, b, VBITS);
    endfunction

    // Advance the predictor by one accepted item; returns 1 when a tendency is due.
    function automatic bit predict_tendency(action_t act, logic [255:0] data,
                                            output tendency_t t);
        longint v [8];
        longint cor [3];
        longint s;
        longint g;
        longint depth;
        longint div;
        longint r [9];
        longint o [4];
        for (int i = 0; i < 8; i++) v[i] = longint'($signed(data[32*i +: 32]));
        t = '{default: '0};
        case (act)
            ACT_NEIGHBOR: begin
                for (int d = 0; d < 4; d++)
                    for (int k = 0; k < 4; k++)
                        sums[d*4+k] = clamp(sums[d*4+k] + qmul(v[d], v[4+k], ACC_BITS),
                                            ACC_BITS);
                return 1'b0;
            end
            ACT_NODE: begin
                for (int i = 0; i < 4; i++) node_state[i] = v[i];
                cor[0] = clamp(vmul(v[6], v[2]) - vmul(v[7], v[1]), VBITS);
                cor[1] = clamp(vmul(v[7], v[0]) - vmul(v[5], v[2]), VBITS);
                cor[2] = clamp(vmul(v[5], v[1]) - vmul(v[6], v[0]), VBITS);
                for (int k = 0; k < 3; k++) begin
                    s = vmul(v[0], sums[k]) + vmul(v[1], sums[4+k])
                      + vmul(v[2], sums[8+k]) + vmul(v[4], cor[k])
                      + clamp(sums[k*4+3], VBITS);
                    momentum[k] = clamp(-clamp(s, VBITS), VBITS);
                end
                return 1'b0;
            end
            ACT_PROJ_A: begin
                for (int i = 0; i < 6; i++) rows_uv[i] = v[i];
                mean_gp = v[6];
                return 1'b0;
            end
            default: begin
                for (int i = 0; i < 6; i++) r[i] = rows_uv[i];
                for (int i = 0; i < 3; i++) r[6+i] = v[i];
                for (int k = 0; k < 3; k++) begin
                    s = vmul(r[k*3], momentum[0]) + vmul(r[k*3+1], momentum[1])
                      + vmul(r[k*3+2], momentum[2]);
                    o[k] = clamp(clamp(s, VBITS) + sums[12+k], 32);
                end
                s = 0;
                for (int d = 0; d < 3; d++) begin
                    g = clamp(sums[d*4+3] - v[3+d], VBITS);
                    s += vmul(node_state[d], g);
                end
                depth = clamp(node_state[3] + gh0 - mean_gp, VBITS);
                div   = clamp(sums[0] + sums[5] + sums[10], VBITS);
                s += vmul(depth, div);
                o[3] = clamp(clamp(-clamp(s, VBITS), VBITS) + sums[15], 32);
                t.u   = o[0][31:0];
                t.v   = o[1][31:0];
                t.w   = o[2][31:0];
                t.h   = o[3][31:0];
                t.sat = clipped;
                for (int i = 0; i < 16; i++) sums[i] = 0;
                clipped = 1'b0;
                return 1'b1;
            end
        endcase
    endfunction

    // Operand mix: half moderate values, the rest extremes and full-range noise.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3, 4:    return $urandom;
            default: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
        endcase
    endfunction

    // Send one transaction and update the predictor when it is accepted.
    task automatic send_item(action_t act, logic [255:0] data);
        tendency_t t;
        if (!quiet && ($urandom_range(0, 3) == 0)) begin
            repeat ($urandom_range(1, 3)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        items_by_action[act]++;
        if (predict_tendency(act, data, t)) tend_queue.push_back(t);
    endtask

    task automatic send_random(action_t act);
        logic [255:0] data;
        for (int i = 0; i < 8; i++) data[32*i +: 32] = pick_value();
        send_item(act, data);
    endtask

    // Lower the input, then wait until every tendency is out and the block is quiet.
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tend_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_gh0(logic [31:0] val);
        drain();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        gh0 = longint'($signed(val));
    endtask

    // One node: a few neighbours, then node state and both projection parts.
    task automatic send_node(int neighbours);
        repeat (neighbours) send_random(ACT_NEIGHBOR);
        send_random(ACT_NODE);
        send_random(ACT_PROJ_A);
        send_random(ACT_PROJ_B);
    endtask

    task automatic test_directed();
        write_gh0(32'h7FFF_FFFF);
        send_item(ACT_PROJ_B, '0);
        send_item(ACT_NEIGHBOR, {8{32'h7FFF_FFFF}});
        send_item(ACT_NEIGHBOR, {8{32'h7FFF_FFFF}});
        send_item(ACT_NODE, {8{32'h7FFF_FFFF}});
        send_item(ACT_PROJ_A, {8{32'h8000_0000}});
        send_item(ACT_PROJ_B, {8{32'h7FFF_FFFF}});
        send_item(ACT_NEIGHBOR, {8{32'h8000_0000}});
        send_item(ACT_NEIGHBOR, {{4{32'h7FFF_FFFF}}, {4{32'h8000_0000}}});
        send_item(ACT_NODE, {8{32'h8000_0000}});
        send_item(ACT_PROJ_B, {8{32'h8000_0000}});
        send_item(ACT_PROJ_B, {8{32'hFFFF_FFFF}});
        write_gh0(32'h8000_0000);
        // A small, well-behaved node with exact halves to exercise rounding.
        send_item(ACT_NEIGHBOR, {32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h0002_0000,
                                 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0001_8000});
        send_item(ACT_NODE, {32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_4000,
                             32'h0003_0000, 32'hFFFF_8000, 32'h0000_8000, 32'h0001_0000});
        send_item(ACT_PROJ_A, {32'hDEAD_BEEF, 32'h0002_0000, 32'h0000_0000, 32'h0000_8000,
                               32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000});
        send_item(ACT_PROJ_B, {32'hCAFE_F00D, 32'h1234_5678, 32'h0000_0001, 32'hFFFF_0000,
                               32'h0000_8000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000});
        send_item(ACT_NODE, '0);
        send_item(ACT_PROJ_A, '0);
        send_item(ACT_PROJ_B, '0);
    endtask

    // Mostly complete nodes with random content, some shuffled action runs.
    task automatic test_random_nodes(int target);
        int start_items;
        start_items = items_by_action[0] + items_by_action[1]
                    + items_by_action[2] + items_by_action[3];
        while (items_by_action[0] + items_by_action[1] + items_by_action[2]
               + items_by_action[3] - start_items < target) begin
            if ($urandom_range(0, 99) < 85) begin
                send_node($urandom_range(0, 8));
            end else begin
                repeat ($urandom_range(1, 6)) send_random(action_t'($urandom_range(0, 3)));
            end
        end
    endtask

    // Receiver blocks for a long stretch while items keep arriving.
    task automatic test_backpressure();
        drain();
        hold_cycles = 400;
        repeat (12) send_node(2);
    endtask

    // Receiver side: random stalls, optional long hold-off.
    initial begin
        int gap;
        gap      = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else if (!quiet && ($urandom_range(0, 4) == 0)) begin
                gap = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker: compares each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        tendency_t e;
        if (aresetn && m_tvalid && m_tready) begin
            tend_seen++;
            if (tend_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction: %h sat %b", m_tdata, m_tuser);
            end else begin
                e = tend_queue.pop_front();
                if (m_tdata[31:0] !== e.u || m_tdata[63:32] !== e.v
                    || m_tdata[95:64] !== e.w || m_tdata[127:96] !== e.h
                    || m_tuser[0] !== e.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected u %h v %h w %h h %h sat %b, got %h sat %b",
                                 e.u, e.v, e.w, e.h, e.sat, m_tdata, m_tuser);
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count > STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb_rbffd_shallow_water_rhs_top: errors");
            $finish;
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ACT_NEIGHBOR;
        quiet       = 1'b0;
        hold_cycles = 0;
        mismatches  = 0;
        tend_seen   = 0;
        idle_count  = 0;
        gh0         = 0;
        mean_gp     = 0;
        clipped     = 1'b0;
        for (int i = 0; i < 16; i++) sums[i] = 0;
        for (int i = 0; i < 4; i++) begin
            node_state[i]      = 0;
            items_by_action[i] = 0;
        end
        for (int i = 0; i < 3; i++) momentum[i] = 0;
        for (int i = 0; i < 6; i++) rows_uv[i] = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        write_gh0(32'h0000_0000);
        test_random_nodes(RAND_ITEMS / 4);
        test_backpressure();
        write_gh0(32'h0010_0000);
        test_random_nodes(RAND_ITEMS / 4);
        write_gh0($urandom);
        test_random_nodes(RAND_ITEMS / 4);
        write_gh0(32'h7FFF_FFFF);
        quiet = 1'b1;
        test_random_nodes(RAND_ITEMS / 4);
        drain();

        $display("Covered %0d neighbour, %0d node, %0d projection-one and %0d emit transactions,",
                 items_by_action[0], items_by_action[1], items_by_action[2], items_by_action[3]);
        $display("%0d tendencies checked over five gh0 settings, with %0d mismatches.",
                 tend_seen, mismatches);
        if (mismatches == 0 && tend_queue.size() == 0) begin
            $display("tb_rbffd_shallow_water_rhs_top: clean");
        end else begin
            $display("tb_rbffd_shallow_water_rhs_top: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rbffd_pkg.sv
rtl/rbffd_mul_lane.sv
rtl/rbffd_shallow_water_rhs_top.sv
tb/tb_rbffd_shallow_water_rhs_top.sv
